### rtl/core/cdrpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdrpc_pkg: shared types and helpers for the cut disc / ring classifier
// Pixel and result beats, configuration set, queue entry, and the sector and
// tangent helpers used by the angle test.
// ----------------------------------------------------------------------------
package cdrpc_pkg;

    localparam logic [12:0] CANVAS_W = 13'd60;
    localparam logic [12:0] CANVAS_H = 13'd22;

    localparam logic [7:0] CHAR_BG   = 8'd46;
    localparam logic [7:0] CHAR_DISC = 8'd79;
    localparam logic [7:0] CHAR_RING = 8'd64;

    localparam logic [4:0] MAX_STEPS  = 5'd20;
    localparam logic [4:0] RING_START = 5'd6;

    typedef enum logic [2:0] {
        REG_CENTER_X   = 3'd0,
        REG_CENTER_Y   = 3'd1,
        REG_RADIUS     = 3'd2,
        REG_RING_WIDTH = 3'd3,
        REG_CUT_STEPS  = 3'd4,
        REG_SHAPE_MODE = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [11:0] pixel_col;
        logic [11:0] pixel_row;
    } pixel_t;

    typedef struct packed {
        logic [7:0] char_code;
        logic       drawn;
    } result_t;

    typedef struct packed {
        logic signed [12:0] center_x;
        logic signed [12:0] center_y;
        logic [7:0]         radius;
        logic [7:0]         ring_width;
        logic [4:0]         cut_steps;
        logic               shape_mode;
    } cfg_t;

    // one classified pixel waiting for the back end
    typedef struct packed {
        logic        on_canvas;
        logic [25:0] aa;
        logic [27:0] bb;
        logic [1:0]  quad;
        logic [13:0] v;
        logic [33:0] prod;
        logic        center;
        logic        disc_start;
        logic        ring_start;
    } work_t;

    typedef struct packed {
        logic empty;
        logic near_full;
    } queue_stat_t;

    function automatic logic [2:0] div6(input logic [4:0] k);
        logic [2:0] d;
        if (k >= 5'd30)
            d = 3'd5;
        else if (k >= 5'd24)
            d = 3'd4;
        else if (k >= 5'd18)
            d = 3'd3;
        else if (k >= 5'd12)
            d = 3'd2;
        else if (k >= 5'd6)
            d = 3'd1;
        else
            d = 3'd0;
        return d;
    endfunction

    function automatic logic [2:0] mod6(input logic [4:0] k);
        logic [2:0] d;
        logic [4:0] m;
        d = div6(k);
        m = k - ({2'b00, d} << 2) - ({2'b00, d} << 1);
        return m[2:0];
    endfunction

    // tangent of 15*t degrees, 18 fractional bits
    function automatic logic [19:0] tan_lookup(input logic [2:0] t);
        logic [19:0] r;
        unique case (t)
            3'd0:    r = 20'd0;
            3'd1:    r = 20'd70241;
            3'd2:    r = 20'd151349;
            3'd3:    r = 20'd262144;
            3'd4:    r = 20'd454047;
            3'd5:    r = 20'd978335;
            default: r = 20'd0;
        endcase
        return r;
    endfunction

    function automatic logic [4:0] clamp_steps(input logic [4:0] s);
        return (s > MAX_STEPS) ? MAX_STEPS : s;
    endfunction

    // angle strictly below 15*k degrees; lt is the tangent compare for k mod 6
    function automatic logic angle_below(input logic [4:0] k, input logic center,
                                         input logic [1:0] quad, input logic lt);
        logic r;
        logic [2:0] kq;
        kq = div6(k);
        if (k == 5'd0)
            r = 1'b0;
        else if (k >= 5'd24)
            r = 1'b1;
        else if (center)
            r = 1'b1;
        else if ({1'b0, quad} != kq)
            r = ({1'b0, quad} < kq);
        else if (mod6(k) == 3'd0)
            r = 1'b0;
        else
            r = lt;
        return r;
    endfunction

endpackage

### rtl/core/cut_disc_ring_pixel_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cut_disc_ring_pixel_classifier: character for one canvas pixel
// Classifies raster pixels against a disc or ring with a pie-slice cut.
// ----------------------------------------------------------------------------
// usage
//   pixel beat: drive pixel and raise start; the beat is taken at a clock
//   edge with start high and busy low
//   result beat: strobe is high for one cycle with result valid; the
//   receiver must take it, there is no backpressure
//   latency: the result strobe is up in the fourth cycle after the accepting
//   edge (two front stages, one queue slot, one output register)
//   throughput: one pixel per clock; the back end drains the queue every
//   cycle, so busy stays low in normal use
//   configuration: apb writes at byte address 4*index, only while idle;
//   prdata returns the register value
//   reset: registers return to centre (20,10), radius 6, ring width 1,
//   cut 4 steps, disc mode; the pipeline and queue empty at once
// ----------------------------------------------------------------------------
module cut_disc_ring_pixel_classifier (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  cdrpc_pkg::pixel_t   pixel,
    output logic                strobe,
    output cdrpc_pkg::result_t  result,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [4:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    cdrpc_pkg::cfg_t        cfg_reg;
    cdrpc_pkg::reg_idx_t    idx;
    cdrpc_pkg::work_t       front_work;
    cdrpc_pkg::work_t       head;
    cdrpc_pkg::queue_stat_t stat;
    logic                   push;
    logic                   pop;
    logic                   accept;
    logic                   wr_en;

    assign pready = 1'b1;
    assign idx    = cdrpc_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_x   <= 13'sd20;
            cfg_reg.center_y   <= 13'sd10;
            cfg_reg.radius     <= 8'd6;
            cfg_reg.ring_width <= 8'd1;
            cfg_reg.cut_steps  <= 5'd4;
            cfg_reg.shape_mode <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                cdrpc_pkg::REG_CENTER_X:   cfg_reg.center_x   <= pwdata[12:0];
                cdrpc_pkg::REG_CENTER_Y:   cfg_reg.center_y   <= pwdata[12:0];
                cdrpc_pkg::REG_RADIUS:     cfg_reg.radius     <= pwdata[7:0];
                cdrpc_pkg::REG_RING_WIDTH: cfg_reg.ring_width <= pwdata[7:0];
                cdrpc_pkg::REG_CUT_STEPS:  cfg_reg.cut_steps  <= pwdata[4:0];
                cdrpc_pkg::REG_SHAPE_MODE: cfg_reg.shape_mode <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            cdrpc_pkg::REG_CENTER_X:   prdata = {{19{cfg_reg.center_x[12]}}, cfg_reg.center_x};
            cdrpc_pkg::REG_CENTER_Y:   prdata = {{19{cfg_reg.center_y[12]}}, cfg_reg.center_y};
            cdrpc_pkg::REG_RADIUS:     prdata = {24'd0, cfg_reg.radius};
            cdrpc_pkg::REG_RING_WIDTH: prdata = {24'd0, cfg_reg.ring_width};
            cdrpc_pkg::REG_CUT_STEPS:  prdata = {27'd0, cfg_reg.cut_steps};
            cdrpc_pkg::REG_SHAPE_MODE: prdata = {31'd0, cfg_reg.shape_mode};
            default:                   prdata = 32'd0;
        endcase
    end

    assign busy   = stat.near_full;
    assign accept = start && !busy;

    cdrpc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .pixel  (pixel),
        .cfg    (cfg_reg),
        .push   (push),
        .work   (front_work)
    );

    cdrpc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_work),
        .pop       (pop),
        .head      (head),
        .stat      (stat)
    );

    cdrpc_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .stat   (stat),
        .head   (head),
        .pop    (pop),
        .strobe (strobe),
        .result (result)
    );

endmodule

### rtl/core/cdrpc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdrpc_front: pixel intake and offset math
// Takes one pixel a cycle, forms the centre offsets, then the squared
// distance terms, the quadrant and the tangent product for the sector edge.
// ----------------------------------------------------------------------------
module cdrpc_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            accept,
    input  cdrpc_pkg::pixel_t pixel,
    input  cdrpc_pkg::cfg_t cfg,
    output logic            push,
    output cdrpc_pkg::work_t work
);

    // stage 1: offsets
    logic               s1_valid_reg;
    logic signed [13:0] a_reg;
    logic signed [14:0] b_reg;
    logic               s1_canvas_reg;

    logic signed [13:0] a_next;
    logic signed [13:0] dy_next;
    logic               canvas_next;

    // stage 2: squares and tangent product
    logic              s2_valid_reg;
    cdrpc_pkg::work_t  work_reg;
    cdrpc_pkg::work_t  work_next;

    logic [12:0] abs_a;
    logic [13:0] abs_b;
    logic        a_pos;
    logic        a_neg;
    logic        b_pos;
    logic        b_neg;
    logic [1:0]  quad;
    logic [13:0] u;
    logic [2:0]  tan_idx;

    always_comb
    begin
        a_next  = $signed({2'b00, pixel.pixel_col}) - $signed({cfg.center_x[12], cfg.center_x});
        dy_next = $signed({2'b00, pixel.pixel_row}) - $signed({cfg.center_y[12], cfg.center_y});
        canvas_next = ({1'b0, pixel.pixel_col} < cdrpc_pkg::CANVAS_W)
                   && ({1'b0, pixel.pixel_row} < cdrpc_pkg::CANVAS_H);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_reg         <= a_next;
            b_reg         <= {dy_next, 1'b0};
            s1_canvas_reg <= canvas_next;
        end
        if (s1_valid_reg)
            work_reg <= work_next;
    end

    always_comb
    begin
        a_pos = !a_reg[13] && (a_reg != 14'sd0);
        a_neg = a_reg[13];
        b_pos = !b_reg[14] && (b_reg != 15'sd0);
        b_neg = b_reg[14];
        abs_a = a_neg ? 13'(-a_reg) : a_reg[12:0];
        abs_b = b_neg ? 14'(-b_reg) : b_reg[13:0];

        if (!b_neg && a_pos)
            quad = 2'd0;
        else if (!a_pos && b_pos)
            quad = 2'd1;
        else if (!b_pos && a_neg)
            quad = 2'd2;
        else
            quad = 2'd3;

        // odd quadrants swap the roles of the two axes
        u = quad[0] ? abs_b : {1'b0, abs_a};

        tan_idx = cdrpc_pkg::mod6(cdrpc_pkg::clamp_steps(cfg.cut_steps));

        work_next.on_canvas  = s1_canvas_reg;
        work_next.aa         = abs_a * abs_a;
        work_next.bb         = abs_b * abs_b;
        work_next.quad       = quad;
        work_next.v          = quad[0] ? {1'b0, abs_a} : abs_b;
        work_next.prod       = u * cdrpc_pkg::tan_lookup(tan_idx);
        work_next.center     = (a_reg == 14'sd0) && (b_reg == 15'sd0);
        work_next.disc_start = (b_reg == 15'sd0) && !a_neg;
        work_next.ring_start = (a_reg == 14'sd0) && b_pos;
    end

    assign push = s2_valid_reg;
    assign work = work_reg;

endmodule

### rtl/core/cdrpc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdrpc_queue: short queue between front and back
// Four-entry queue of classified pixels; flags near full early enough to
// cover the beats still in the front pipeline.
// ----------------------------------------------------------------------------
module cdrpc_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  cdrpc_pkg::work_t       push_data,
    input  logic                   pop,
    output cdrpc_pkg::work_t       head,
    output cdrpc_pkg::queue_stat_t stat
);

    cdrpc_pkg::work_t mem [4];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic       do_pop;

    assign do_pop = pop && (count_reg != 3'd0);

    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
            count_next = count_reg + 3'd1;
        else if (!push && do_pop)
            count_next = count_reg - 3'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 2'd0;
            rd_ptr_reg <= 2'd0;
            count_reg  <= 3'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    assign head           = mem[rd_ptr_reg];
    assign stat.empty     = (count_reg == 3'd0);
    // two beats may still be in flight in the front pipeline
    assign stat.near_full = (count_reg >= 3'd2);

endmodule

### rtl/core/cdrpc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdrpc_back: distance and sector decision
// Pops one classified pixel a cycle while the queue is not empty, checks the
// outer and inner edges and cut sector; registers the result beat and strobe.
// ----------------------------------------------------------------------------
module cdrpc_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cdrpc_pkg::cfg_t        cfg,
    input  cdrpc_pkg::queue_stat_t stat,
    input  cdrpc_pkg::work_t       head,
    output logic                   pop,
    output logic                   strobe,
    output cdrpc_pkg::result_t     result
);

    logic [17:0] outer_sq_reg;
    logic [17:0] inner_sq_reg;
    logic        inner_pos_reg;

    logic signed [8:0] inner;
    logic [8:0]        diam;
    logic [8:0]        inner_diam;

    logic               strobe_reg;
    cdrpc_pkg::result_t result_reg;
    cdrpc_pkg::result_t result_next;

    logic [28:0] d2;
    logic        outer_ok;
    logic        band_ok;
    logic        lt;
    logic [4:0]  k;
    logic        disc_cut;
    logic        ring_cut;

    // edge thresholds are registered and follow the configuration in the next cycle
    always_comb
    begin
        inner      = $signed({1'b0, cfg.radius}) - $signed({1'b0, cfg.ring_width});
        diam       = {cfg.radius, 1'b0};
        inner_diam = {inner[7:0], 1'b0};
    end

    always_ff @(posedge clk)
    begin
        outer_sq_reg  <= diam * diam;
        inner_sq_reg  <= inner_diam * inner_diam;
        inner_pos_reg <= !inner[8] && (inner != 9'sd0);
    end

    assign pop = !stat.empty;

    always_comb
    begin
        d2       = {3'b000, head.aa} + {1'b0, head.bb};
        outer_ok = d2 <= {11'd0, outer_sq_reg};
        band_ok  = !inner_pos_reg || (d2 >= {11'd0, inner_sq_reg});
        lt       = {2'b00, head.v, 18'd0} < head.prod;
        k        = cdrpc_pkg::clamp_steps(cfg.cut_steps);

        disc_cut = head.disc_start
                || cdrpc_pkg::angle_below(k, head.center, head.quad, lt);
        ring_cut = head.ring_start
                || (!cdrpc_pkg::angle_below(cdrpc_pkg::RING_START, head.center, head.quad, lt)
                    && cdrpc_pkg::angle_below(cdrpc_pkg::RING_START + k, head.center,
                                              head.quad, lt));

        result_next.char_code = cdrpc_pkg::CHAR_BG;
        result_next.drawn     = 1'b0;
        if (head.on_canvas && outer_ok)
        begin
            if (!cfg.shape_mode)
            begin
                if (!disc_cut)
                begin
                    result_next.char_code = cdrpc_pkg::CHAR_DISC;
                    result_next.drawn     = 1'b1;
                end
            end
            else if (band_ok && !ring_cut)
            begin
                result_next.char_code = cdrpc_pkg::CHAR_RING;
                result_next.drawn     = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= pop;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            result_reg <= result_next;
    end

    assign strobe = strobe_reg;
    assign result = result_reg;

endmodule
